@@ hw/rtl/sha256_byte_stream_hasher_assert.svh @@
// assertion macros for the sha-256 byte stream hasher
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define SBH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define SBH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/sha_bsh_pkg.sv @@
// types, constants and round functions of the sha-256 byte stream hasher
package sha_bsh_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_FINAL,
    S_OUT
  } state_t;

  localparam logic [7:0] PAD_LEAD  = 8'h80;
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [3:0] LEN_BYTES = 4'd8;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

@@ hw/rtl/sha256_byte_stream_hasher.sv @@
// sha-256 hasher taking one message byte per word and returning the digest as eight words
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------------------
//   in      | input     | in_valid, in_stall | in_data_byte, in_byte_valid, in_last_byte
//   out     | output    | out_valid,out_stall| out_digest_word, out_word_index, out_digest_done
//
// a plain byte word is packed into the block; the byte that fills a 64-byte block starts a compression
// (64 rounds of the shared round unit, then the chaining add)
// a last word pads one byte per cycle over one or two blocks, runs one or two
// compressions, then gives the eight digest words
// in_stall is high whenever the sequencer is not idle; out_stall holds the current word
// rst_n is synchronous: chain words return to the initial hash values, counters to zero
`include "sha256_byte_stream_hasher_assert.svh"

module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_digest_done
);

  // control state
  sha_bsh_pkg::state_t state_r, state_nxt;
  logic [31:0] chain_r [8];
  logic [31:0] chain_nxt [8];
  logic [63:0] byte_total_r, byte_total_nxt;
  logic [3:0]  word_fill_r, word_fill_nxt;
  logic [31:0] partial_r, partial_nxt;
  logic [1:0]  byte_in_word_r, byte_in_word_nxt;
  logic        pad_r, pad_nxt;         // padding in progress for this message
  logic        lead_r, lead_nxt;       // next padding byte is the 0x80 marker
  logic [3:0]  len_cnt_r, len_cnt_nxt; // length bytes already packed
  logic [5:0]  round_r, round_nxt;
  logic [2:0]  out_cnt_r, out_cnt_nxt;

  // payload state, no reset
  logic [31:0] blk_r [16];             // block words, also the rolling schedule window
  logic [31:0] blk_nxt [16];
  logic [31:0] work_r [8];             // working variables a..h
  logic [31:0] work_nxt [8];
  logic [63:0] len_r, len_nxt;         // bit length, sent msb byte first

  // shared byte packer
  logic        absorb_en;
  logic [7:0]  absorb_byte;
  logic        word_end;
  logic        block_end;

  // round unit
  logic [31:0] t1, t2, sched_word;
  logic [63:0] total_inc;
  logic [5:0]  pos;
  logic [7:0]  pad_byte;
  logic        len_phase;

  assign pos       = {word_fill_r, byte_in_word_r};
  assign word_end  = (byte_in_word_r == 2'd3);
  assign block_end = word_end && (word_fill_r == 4'd15);
  assign total_inc = byte_total_r + {63'd0, in_byte_valid};

  // after the marker: zeros until byte 56 of the block, then eight length bytes
  assign len_phase = !lead_r && ((pos == sha_bsh_pkg::LEN_POS) || (len_cnt_r != 4'd0));
  assign pad_byte  = lead_r ? sha_bsh_pkg::PAD_LEAD : (len_phase ? len_r[63:56] : 8'h00);

  assign t1 = work_r[7] + sha_bsh_pkg::big_sigma1(work_r[4])
            + sha_bsh_pkg::choose(work_r[4], work_r[5], work_r[6])
            + sha_bsh_pkg::ROUND_K[round_r] + blk_r[0];
  assign t2 = sha_bsh_pkg::big_sigma0(work_r[0])
            + sha_bsh_pkg::majority(work_r[0], work_r[1], work_r[2]);
  // w[t+16] from the window that holds w[t] .. w[t+15]
  assign sched_word = blk_r[0] + sha_bsh_pkg::small_sigma0(blk_r[1]) + blk_r[9]
                    + sha_bsh_pkg::small_sigma1(blk_r[14]);

  assign in_stall        = (state_r != sha_bsh_pkg::S_IDLE);
  assign out_valid       = (state_r == sha_bsh_pkg::S_OUT);
  assign out_digest_word = chain_r[0];
  assign out_word_index  = out_cnt_r;
  assign out_digest_done = (out_cnt_r == 3'd7);

  always_comb begin
    state_nxt        = state_r;
    chain_nxt        = chain_r;
    byte_total_nxt   = byte_total_r;
    word_fill_nxt    = word_fill_r;
    partial_nxt      = partial_r;
    byte_in_word_nxt = byte_in_word_r;
    pad_nxt          = pad_r;
    lead_nxt         = lead_r;
    len_cnt_nxt      = len_cnt_r;
    round_nxt        = round_r;
    out_cnt_nxt      = out_cnt_r;
    blk_nxt          = blk_r;
    work_nxt         = work_r;
    len_nxt          = len_r;
    absorb_en        = 1'b0;
    absorb_byte      = pad_byte;

    case (state_r)
      sha_bsh_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_byte_valid) begin
            absorb_en      = 1'b1;
            absorb_byte    = in_data_byte;
            byte_total_nxt = total_inc;
          end
          if (in_last_byte) begin
            len_nxt        = {total_inc[60:0], 3'b000};
            byte_total_nxt = 64'd0;
            pad_nxt        = 1'b1;
            lead_nxt       = 1'b1;
            len_cnt_nxt    = 4'd0;
          end
          if (in_byte_valid && block_end) begin
            work_nxt  = chain_r;
            round_nxt = 6'd0;
            state_nxt = sha_bsh_pkg::S_ROUND;
          end else if (in_last_byte) begin
            state_nxt = sha_bsh_pkg::S_PAD;
          end
        end
      end
      sha_bsh_pkg::S_PAD: begin
        absorb_en = 1'b1;
        lead_nxt  = 1'b0;
        if (len_phase) begin
          len_nxt     = {len_r[55:0], 8'h00};
          len_cnt_nxt = len_cnt_r + 4'd1;
        end
        if (block_end) begin
          work_nxt  = chain_r;
          round_nxt = 6'd0;
          state_nxt = sha_bsh_pkg::S_ROUND;
        end
      end
      sha_bsh_pkg::S_ROUND: begin
        work_nxt[7] = work_r[6];
        work_nxt[6] = work_r[5];
        work_nxt[5] = work_r[4];
        work_nxt[4] = work_r[3] + t1;
        work_nxt[3] = work_r[2];
        work_nxt[2] = work_r[1];
        work_nxt[1] = work_r[0];
        work_nxt[0] = t1 + t2;
        for (int i = 0; i < 15; i++) begin
          blk_nxt[i] = blk_r[i + 1];
        end
        blk_nxt[15] = sched_word;
        round_nxt   = round_r + 6'd1;
        if (round_r == 6'd63) begin
          state_nxt = sha_bsh_pkg::S_FINAL;
        end
      end
      sha_bsh_pkg::S_FINAL: begin
        for (int i = 0; i < 8; i++) begin
          chain_nxt[i] = chain_r[i] + work_r[i];
        end
        if (len_cnt_r == sha_bsh_pkg::LEN_BYTES) begin
          out_cnt_nxt = 3'd0;
          state_nxt   = sha_bsh_pkg::S_OUT;
        end else if (pad_r) begin
          state_nxt = sha_bsh_pkg::S_PAD;
        end else begin
          state_nxt = sha_bsh_pkg::S_IDLE;
        end
      end
      sha_bsh_pkg::S_OUT: begin
        if (!out_stall) begin
          // rotate so the next digest word sits at the output
          for (int i = 0; i < 7; i++) begin
            chain_nxt[i] = chain_r[i + 1];
          end
          chain_nxt[7] = chain_r[0];
          out_cnt_nxt  = out_cnt_r + 3'd1;
          if (out_cnt_r == 3'd7) begin
            chain_nxt   = sha_bsh_pkg::INIT_HASH;
            pad_nxt     = 1'b0;
            len_cnt_nxt = 4'd0;
            state_nxt   = sha_bsh_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = sha_bsh_pkg::S_IDLE;
      end
    endcase

    // byte packer: big-endian into words, full words shift into the block window
    if (absorb_en) begin
      byte_in_word_nxt = byte_in_word_r + 2'd1;
      if (word_end) begin
        for (int i = 0; i < 15; i++) begin
          blk_nxt[i] = blk_r[i + 1];
        end
        blk_nxt[15]   = {partial_r[23:0], absorb_byte};
        partial_nxt   = 32'd0;
        word_fill_nxt = word_fill_r + 4'd1;
      end else begin
        partial_nxt = {partial_r[23:0], absorb_byte};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= sha_bsh_pkg::S_IDLE;
      chain_r        <= sha_bsh_pkg::INIT_HASH;
      byte_total_r   <= 64'd0;
      word_fill_r    <= 4'd0;
      partial_r      <= 32'd0;
      byte_in_word_r <= 2'd0;
      pad_r          <= 1'b0;
      lead_r         <= 1'b0;
      len_cnt_r      <= 4'd0;
      round_r        <= 6'd0;
      out_cnt_r      <= 3'd0;
    end else begin
      state_r        <= state_nxt;
      chain_r        <= chain_nxt;
      byte_total_r   <= byte_total_nxt;
      word_fill_r    <= word_fill_nxt;
      partial_r      <= partial_nxt;
      byte_in_word_r <= byte_in_word_nxt;
      pad_r          <= pad_nxt;
      lead_r         <= lead_nxt;
      len_cnt_r      <= len_cnt_nxt;
      round_r        <= round_nxt;
      out_cnt_r      <= out_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r  <= blk_nxt;
    work_r <= work_nxt;
    len_r  <= len_nxt;
  end

  // no new input while a digest is pending
  `SBH_ASSERT_NOW(a_out_blocks_in, out_valid, in_stall, "input accepted during digest output")
  // chaining add only after the sixty-fourth round
  `SBH_ASSERT_NOW(a_final_after_rounds, state_r == sha_bsh_pkg::S_FINAL,
                  $past(round_r) == 6'd63, "chaining add before all rounds ran")
  // digest only once padding closed the block exactly
  `SBH_ASSERT_NOW(a_out_block_aligned, out_valid,
                  word_fill_r == 4'd0 && byte_in_word_r == 2'd0 &&
                  len_cnt_r == sha_bsh_pkg::LEN_BYTES, "digest with unaligned padding")
  // last digest word returns the block to a fresh message
  `SBH_ASSERT_NEXT(a_done_restarts, out_valid && !out_stall && out_digest_done,
                   state_r == sha_bsh_pkg::S_IDLE && byte_total_r == 64'd0 &&
                   chain_r[0] == sha_bsh_pkg::INIT_HASH[0], "no clean restart after digest")

endmodule
